// File: hw/rtl/usan_pkg.sv
// usan_pkg: shared types, constants and helper functions for the utf-8 sanitizer
// used by usan_front, usan_back, the top level and the checker
package usan_pkg;

  // default output counter width and queue depths
  localparam int USAN_COUNT_WIDTH = 16;
  localparam int USAN_IN_DEPTH    = 4;
  localparam int USAN_OUT_DEPTH   = 4;

  // configuration port
  localparam int               USAN_ADDR_W       = 2;
  localparam logic [1:0]       USAN_ADDR_LIMIT   = 2'd0;
  localparam logic [15:0]      USAN_LIMIT_RESET  = 16'hffff;

  // byte ranges
  localparam logic [7:0] USAN_ASCII_TOP = 8'h80;
  localparam logic [7:0] USAN_LEAD2_LO  = 8'hc2;
  localparam logic [7:0] USAN_LEAD2_HI  = 8'hdf;
  localparam logic [7:0] USAN_LEAD3_LO  = 8'he0;
  localparam logic [7:0] USAN_LEAD3_HI  = 8'hef;
  localparam logic [7:0] USAN_LEAD4_LO  = 8'hf0;
  localparam logic [7:0] USAN_LEAD4_HI  = 8'hf4;
  localparam logic [7:0] USAN_E0_MIN    = 8'ha0;
  localparam logic [7:0] USAN_LEAD_ED   = 8'hed;
  localparam logic [7:0] USAN_ED_MAX    = 8'h9f;
  localparam logic [7:0] USAN_F0_MIN    = 8'h90;
  localparam logic [7:0] USAN_F4_MAX    = 8'h8f;
  localparam logic [1:0] USAN_CONT_TAG  = 2'b10;

  // replacement character u+fffd
  localparam logic [7:0] USAN_REPL_0 = 8'hef;
  localparam logic [7:0] USAN_REPL_1 = 8'hbf;
  localparam logic [7:0] USAN_REPL_2 = 8'hbd;

  // classified byte: width is 1 for ascii, 2..4 for a valid lead, 0 otherwise
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] width;
    logic       cont;
  } usan_byte_t;

  // item between front and back
  typedef struct packed {
    usan_byte_t b;
    logic       last;
  } usan_item_t;

  // result item
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } usan_out_t;

  // up to four bytes waiting to be parsed
  typedef usan_byte_t [3:0] usan_pend_t;

  function automatic usan_byte_t usan_classify(input logic [7:0] d);
    usan_byte_t r;
    r.data = d;
    r.cont = (d[7:6] == USAN_CONT_TAG);
    if (d < USAN_ASCII_TOP) begin
      r.width = 3'd1;
    end else if (d >= USAN_LEAD2_LO && d <= USAN_LEAD2_HI) begin
      r.width = 3'd2;
    end else if (d >= USAN_LEAD3_LO && d <= USAN_LEAD3_HI) begin
      r.width = 3'd3;
    end else if (d >= USAN_LEAD4_LO && d <= USAN_LEAD4_HI) begin
      r.width = 3'd4;
    end else begin
      r.width = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [7:0] usan_repl_byte(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = USAN_REPL_0;
      2'd1:    r = USAN_REPL_1;
      default: r = USAN_REPL_2;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/usan_fifo.sv
// usan_fifo: small register queue with push/full and pop/empty sides
// standalone, no package dependency; depth must be a power of two
module usan_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: hw/rtl/usan_front.sv
// usan_front: accepts input items, classifies each byte and queues it for the back end
// depends on usan_pkg and usan_fifo
module usan_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 final_byte,
  output logic                 full,
  input  logic                 q_pop,
  output usan_pkg::usan_item_t q_item,
  output logic                 q_empty
);
  import usan_pkg::*;

  usan_item_t in_item;

  // classify the byte on the way in
  always_comb begin
    in_item.b    = usan_classify(data_byte);
    in_item.last = final_byte;
  end

  // decoupling queue toward the sequencer
  usan_fifo #(
    .WIDTH($bits(usan_item_t)),
    .DEPTH(USAN_IN_DEPTH)
  ) u_in_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(in_item),
    .full     (full),
    .pop      (q_pop),
    .pop_data (q_item),
    .empty    (q_empty)
  );

endmodule

// File: hw/rtl/usan_back.sv
// usan_back: sequencer that parses queued bytes, checks the limit and emits result items
// depends on usan_pkg
module usan_back #(
  parameter int COUNT_WIDTH = usan_pkg::USAN_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          byte_limit,
  input  usan_pkg::usan_item_t q_item,
  input  logic                 q_empty,
  output logic                 q_pop,
  output usan_pkg::usan_out_t  out_item,
  output logic                 out_push,
  input  logic                 out_full
);
  import usan_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

  typedef enum logic [1:0] {S_LOAD, S_PARSE, S_EMIT, S_CLOSE} state_t;

  state_t          state, state_next;
  usan_pend_t      pend, pend_next;
  logic [2:0]      cnt, cnt_next;
  logic            fin, fin_next;
  logic [CW-1:0]   emitted, emitted_next;
  logic            stopped, stopped_next;
  logic [7:0]      held_data, held_data_next;
  logic            held_valid, held_valid_next;
  logic [2:0]      amount, amount_next;
  logic [1:0]      idx, idx_next;
  logic            repl, repl_next;

  logic [32:0]     lim_wide;
  logic [CW-1:0]   lim_sat;
  usan_byte_t      lead;
  logic            seq_ok;
  logic            is_short;
  logic            act_wait;
  logic            act_repl;
  logic [2:0]      amt;
  logic            over;
  logic [7:0]      first_data;
  logic            blocked;
  logic            load_ok;
  logic            take;
  logic            emit_en;
  logic [7:0]      emit_data;
  logic [2:0]      emit_step;

  function automatic usan_pend_t shift_pend(input usan_pend_t p, input logic [2:0] s);
    usan_pend_t r;
    r = p;
    case (s)
      3'd1: begin
        r[0] = p[1];
        r[1] = p[2];
        r[2] = p[3];
      end
      3'd2: begin
        r[0] = p[2];
        r[1] = p[3];
      end
      3'd3: r[0] = p[3];
      default: ;
    endcase
    return r;
  endfunction

  // effective limit, saturated to the counter range
  always_comb begin
    lim_wide = {17'd0, byte_limit};
    lim_sat  = (lim_wide > CNT_MAX) ? CNT_MAX[CW-1:0] : lim_wide[CW-1:0];
  end

  // decision for the sequence that starts at the oldest pending byte
  always_comb begin
    lead   = pend[0];
    seq_ok = (lead.width != 3'd0);
    if (cnt > 3'd1 && lead.width > 3'd1 && !pend[1].cont) seq_ok = 1'b0;
    if (cnt > 3'd2 && lead.width > 3'd2 && !pend[2].cont) seq_ok = 1'b0;
    if (cnt > 3'd3 && lead.width > 3'd3 && !pend[3].cont) seq_ok = 1'b0;
    // overlong, surrogate and out-of-range second bytes
    if (cnt >= 3'd2 && lead.width == 3'd3) begin
      if ((lead.data == USAN_LEAD3_LO && pend[1].data < USAN_E0_MIN) ||
          (lead.data == USAN_LEAD_ED && pend[1].data > USAN_ED_MAX)) seq_ok = 1'b0;
    end
    if (cnt >= 3'd2 && lead.width == 3'd4) begin
      if ((lead.data == USAN_LEAD4_LO && pend[1].data < USAN_F0_MIN) ||
          (lead.data == USAN_LEAD4_HI && pend[1].data > USAN_F4_MAX)) seq_ok = 1'b0;
    end
    is_short   = (cnt < lead.width);
    act_wait   = seq_ok && is_short && !fin;
    act_repl   = !seq_ok || (is_short && fin);
    amt        = act_repl ? 3'd3 : lead.width;
    over       = (({1'b0, emitted} + (CW+1)'(amt)) > {1'b0, lim_sat});
    first_data = act_repl ? USAN_REPL_0 : lead.data;
  end

  assign blocked   = out_full && (held_valid || !fin);
  assign load_ok   = !q_empty;
  assign emit_step = repl ? 3'd1 : amount;

  // sequencer next state
  always_comb begin
    state_next      = state;
    pend_next       = pend;
    cnt_next        = cnt;
    fin_next        = fin;
    emitted_next    = emitted;
    stopped_next    = stopped;
    held_data_next  = held_data;
    held_valid_next = held_valid;
    amount_next     = amount;
    idx_next        = idx;
    repl_next       = repl;
    out_push        = 1'b0;
    out_item        = '{data: held_data, present: 1'b1, last: 1'b0};
    q_pop           = 1'b0;
    take            = 1'b0;
    emit_en         = 1'b0;
    emit_data       = first_data;

    unique case (state)
      S_LOAD: begin
        take = load_ok;
      end
      S_PARSE: begin
        if (cnt == 3'd0 || act_wait) begin
          // step done; pending prefix stays for the next item
          if (fin) begin
            state_next = S_CLOSE;
          end else begin
            take       = load_ok;
            state_next = S_LOAD;
          end
        end else if (over) begin
          stopped_next = 1'b1;
          cnt_next     = 3'd0;
          state_next   = fin ? S_CLOSE : S_LOAD;
        end else if (!blocked) begin
          emit_en   = 1'b1;
          emit_data = first_data;
          if (amt == 3'd1) begin
            pend_next    = shift_pend(pend, 3'd1);
            cnt_next     = cnt - 3'd1;
            emitted_next = emitted + CW'(1);
          end else begin
            state_next  = S_EMIT;
            idx_next    = 2'd1;
            amount_next = amt;
            repl_next   = act_repl;
          end
        end
      end
      S_EMIT: begin
        if (!blocked) begin
          emit_en   = 1'b1;
          emit_data = repl ? usan_repl_byte(idx) : pend[idx].data;
          idx_next  = idx + 2'd1;
          if ({1'b0, idx} == amount - 3'd1) begin
            emitted_next = emitted + {{(CW-3){1'b0}}, amount};
            pend_next    = shift_pend(pend, emit_step);
            cnt_next     = cnt - emit_step;
            state_next   = S_PARSE;
          end
        end
      end
      S_CLOSE: begin
        if (!out_full) begin
          out_push = 1'b1;
          if (held_valid) begin
            out_item = '{data: held_data, present: 1'b1, last: 1'b1};
          end else begin
            out_item = '{data: 8'h00, present: 1'b0, last: 1'b1};
          end
          held_valid_next = 1'b0;
          cnt_next        = 3'd0;
          emitted_next    = '0;
          stopped_next    = 1'b0;
          fin_next        = 1'b0;
          state_next      = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase

    // one byte out: in the final step the newest byte is held back so the
    // closing cycle can mark it, elsewhere it goes straight to the queue
    if (emit_en) begin
      if (!fin) begin
        out_push = 1'b1;
        out_item = '{data: emit_data, present: 1'b1, last: 1'b0};
      end else begin
        if (held_valid) begin
          out_push = 1'b1;
          out_item = '{data: held_data, present: 1'b1, last: 1'b0};
        end
        held_data_next  = emit_data;
        held_valid_next = 1'b1;
      end
    end

    // take the next queued item
    if (take) begin
      q_pop = 1'b1;
      if (stopped) begin
        state_next = q_item.last ? S_CLOSE : S_LOAD;
      end else begin
        pend_next[cnt[1:0]] = q_item.b;
        cnt_next            = cnt + 3'd1;
        fin_next            = q_item.last;
        state_next          = S_PARSE;
      end
    end
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      cnt        <= 3'd0;
      fin        <= 1'b0;
      emitted    <= '0;
      stopped    <= 1'b0;
      held_valid <= 1'b0;
      amount     <= 3'd0;
      idx        <= 2'd0;
      repl       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      fin        <= fin_next;
      emitted    <= emitted_next;
      stopped    <= stopped_next;
      held_valid <= held_valid_next;
      amount     <= amount_next;
      idx        <= idx_next;
      repl       <= repl_next;
    end
    pend      <= pend_next;
    held_data <= held_data_next;
  end

endmodule

// File: hw/rtl/utf8_sanitize_bounded.sv
// utf8_sanitize_bounded: top level of the bounded utf-8 sanitizer
// depends on usan_pkg, usan_front, usan_back and usan_fifo
//
//   channel   handshake             payload
//   input     push / full           data_byte, final_byte
//   result    pop / empty           out_byte, byte_present, string_end
//   config    apb (psel, penable)   byte_limit at byte address 0
//
// the sequencer loads input items one at a time and emits output bytes one at
// a time; a copied sequence of w bytes is emitted once all w bytes are loaded,
// a replacement as the three bytes of u+fffd
// the final item of a string ends with a closing result
// reset clears both four-entry queues and all string state; byte_limit resets to 65535
// with pop low the result queue fills and the sequencer waits; full rises when
// the input queue holds four items
module utf8_sanitize_bounded #(
  parameter int COUNT_WIDTH = usan_pkg::USAN_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte,
  input  logic                           final_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           byte_present,
  output logic                           string_end,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [usan_pkg::USAN_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import usan_pkg::*;

  logic [15:0] byte_limit;
  logic        cfg_wr;
  usan_item_t  q_item;
  logic        q_empty;
  logic        q_pop;
  usan_out_t   res_in;
  usan_out_t   res_out;
  logic        res_push;
  logic        res_full;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == USAN_ADDR_LIMIT);
  assign prdata = (paddr == USAN_ADDR_LIMIT) ? {16'd0, byte_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= USAN_LIMIT_RESET;
    end else if (cfg_wr) begin
      byte_limit <= pwdata[15:0];
    end
  end

  // front: accept and classify
  usan_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .final_byte(final_byte),
    .full      (full),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_empty   (q_empty)
  );

  // back: parse, bound and emit
  usan_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .byte_limit(byte_limit),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (res_in),
    .out_push  (res_push),
    .out_full  (res_full)
  );

  // result queue
  usan_fifo #(
    .WIDTH($bits(usan_out_t)),
    .DEPTH(USAN_OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (pop),
    .pop_data (res_out),
    .empty    (empty)
  );

  assign out_byte     = res_out.data;
  assign byte_present = res_out.present;
  assign string_end   = res_out.last;

endmodule

// File: hw/rtl/usan_checker.sv
// usan_checker: port-level assertions for utf8_sanitize_bounded, with its bind
// depends on usan_pkg for the register address
module usan_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             empty,
  input logic                             pop,
  input logic [7:0]                       out_byte,
  input logic                             byte_present,
  input logic                             string_end,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [usan_pkg::USAN_ADDR_W-1:0] paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata
);
  import usan_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // a bare marker always closes a string
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_present) |-> string_end)
    else $error("bare result without string end");

  // a bare marker carries a zero byte
  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_present) |-> (out_byte == 8'h00))
    else $error("bare result with nonzero byte");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(string_end)))
    else $error("waiting result changed");

  // a limit write reads back
  a_limit_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr == USAN_ADDR_LIMIT) |=>
      (paddr != USAN_ADDR_LIMIT || prdata[15:0] == $past(pwdata[15:0])))
    else $error("byte limit readback mismatch");

endmodule

bind utf8_sanitize_bounded usan_checker u_usan_checker (.*);
